FILE: design/ectp_pkg.sv
`timescale 1ns / 1ps
package ectp_pkg;

  localparam int unsigned FracBits = 16;
  localparam int unsigned DvdW     = 32 + FracBits;
  localparam int unsigned CntW     = $clog2(DvdW + 1);
  localparam int unsigned QDepth   = 4;
  localparam int unsigned QAw      = $clog2(QDepth);

  typedef struct packed {
    logic        jack_present;
    logic        jack_level;
    logic        bus_level;
    logic [31:0] timestamp;
  } in_word_t;

  typedef struct packed {
    logic [31:0] smoothed_period;
    logic        external_active;
    logic        waiting_flag;
    logic [7:0]  wait_progress;
    logic        resync_pulse;
    logic        recalc_pulse;
  } out_word_t;

  typedef enum logic [1:0] {
    CMD_HOLD,
    CMD_FIRST,
    CMD_EDGE,
    CMD_LOW
  } cmd_e;

  typedef struct packed {
    cmd_e        cmd;
    logic [31:0] interval;
  } cmd_t;

  typedef enum logic [1:0] {
    REG_ALLOW_BUS = 2'd0,
    REG_CYCLES    = 2'd1,
    REG_MIN       = 2'd2
  } reg_e;

  typedef struct packed {
    logic        allow_bus;
    logic [31:0] cycles_per_tick;
    logic [31:0] min_period;
  } cfg_t;

endpackage

FILE: design/ectp_front.sv
`timescale 1ns / 1ps
module ectp_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  input  ectp_pkg::in_word_t in_word_i,
  input  ectp_pkg::cfg_t     cfg_i,
  input  logic               q_full_i,
  output logic               cmd_valid_o,
  output ectp_pkg::cmd_t     cmd_o
);

  logic        level_high_q, edge_seen_q;
  logic [31:0] last_q;
  logic        level, rising, accept;

  assign accept = push && !q_full_i;
  assign level  = in_word_i.jack_present ? in_word_i.jack_level
                                         : (cfg_i.allow_bus && in_word_i.bus_level);
  assign rising = level && !level_high_q;

  always_comb begin
    cmd_o.interval = in_word_i.timestamp - last_q;
    if (rising) begin
      cmd_o.cmd = edge_seen_q ? ectp_pkg::CMD_EDGE : ectp_pkg::CMD_FIRST;
    end else if (!level) begin
      cmd_o.cmd = ectp_pkg::CMD_LOW;
    end else begin
      cmd_o.cmd = ectp_pkg::CMD_HOLD;
    end
  end

  assign cmd_valid_o = accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_high_q <= 1'b0;
      edge_seen_q  <= 1'b0;
      last_q       <= '0;
    end else if (accept) begin
      level_high_q <= level;
      if (rising) begin
        edge_seen_q <= 1'b1;
        last_q      <= in_word_i.timestamp;
      end
    end
  end

endmodule

FILE: design/ectp_fifo.sv
`timescale 1ns / 1ps
module ectp_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           wr_i,
  input  ectp_pkg::cmd_t wdata_i,
  input  logic           rd_i,
  output ectp_pkg::cmd_t rdata_o,
  output logic           full_o,
  output logic           empty_o
);

  ectp_pkg::cmd_t              mem_q [ectp_pkg::QDepth];
  logic [ectp_pkg::QAw-1:0]    wp_q, rp_q;
  logic [ectp_pkg::QAw:0]      cnt_q;

  assign full_o  = (cnt_q == (ectp_pkg::QAw+1)'(ectp_pkg::QDepth));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem_q[wp_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (wr_i) begin
        wp_q <= wp_q + 1'b1;
      end
      if (rd_i) begin
        rp_q <= rp_q + 1'b1;
      end
      case ({wr_i, rd_i})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

FILE: design/ectp_back.sv
`timescale 1ns / 1ps
module ectp_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ectp_pkg::cfg_t      cfg_i,
  input  logic                q_empty_i,
  input  ectp_pkg::cmd_t      q_data_i,
  output logic                q_rd_o,
  input  logic                pop,
  output logic                empty,
  output ectp_pkg::out_word_t out_word_o
);

  localparam int unsigned DvdW = ectp_pkg::DvdW;
  localparam int unsigned CntW = ectp_pkg::CntW;
  localparam int unsigned Frac = ectp_pkg::FracBits;

  typedef enum logic [2:0] {
    S_IDLE, S_DIV, S_POST, S_DBL, S_UPD, S_PROG, S_PFIN, S_OUT
  } state_e;

  state_e              state_q;
  ectp_pkg::cmd_e      cmd_q;
  logic [31:0]         period_q, tp_q, rem_q;
  logic                ext_q, wait_q, resync_q, recalc_q, out_valid_q;
  logic [7:0]          prog_q;
  logic [DvdW-1:0]     quo_q;
  logic [CntW-1:0]     cnt_q;
  logic [33:0]         pr_q;
  logic [8:0]          pb_q;
  ectp_pkg::out_word_t out_q;

  logic [31:0]     dsr;
  logic [32:0]     r_sh, twice;
  logic            ge, pbit;
  logic [31:0]     tp_sat, diff;
  logic [DvdW-1:0] elapsed;
  logic [38:0]     diff100;
  logic [34:0]     blend;

  assign dsr     = (cfg_i.cycles_per_tick == '0) ? 32'd1 : cfg_i.cycles_per_tick;
  assign r_sh    = {rem_q, quo_q[DvdW-1]};
  assign ge      = r_sh >= {1'b0, dsr};
  assign twice   = {period_q, 1'b0};
  assign pbit    = pr_q >= 34'(twice);
  assign tp_sat  = (|quo_q[DvdW-1:32]) ? '1 : quo_q[31:0];
  assign elapsed = {quo_q[31:0], {Frac{1'b0}}};
  assign diff    = (tp_q > period_q) ? tp_q - period_q : period_q - tp_q;
  assign diff100 = (39'(diff) << 6) + (39'(diff) << 5) + (39'(diff) << 2);
  assign blend   = (35'(period_q) << 3) - 35'(period_q) + 35'(tp_q);

  assign q_rd_o     = (state_q == S_IDLE) && !q_empty_i;
  assign empty      = !out_valid_q;
  assign out_word_o = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cmd_q       <= ectp_pkg::CMD_HOLD;
      period_q    <= '0;
      ext_q       <= 1'b0;
      wait_q      <= 1'b0;
      prog_q      <= '0;
      resync_q    <= 1'b0;
      recalc_q    <= 1'b0;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
      tp_q        <= '0;
      rem_q       <= '0;
      quo_q       <= '0;
      pr_q        <= '0;
      pb_q        <= '0;
      out_q       <= '0;
    end else begin
      if (pop && out_valid_q && (state_q != S_OUT)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (!q_empty_i) begin
            cmd_q    <= q_data_i.cmd;
            resync_q <= 1'b0;
            recalc_q <= 1'b0;
            rem_q    <= '0;
            cnt_q    <= '0;
            if (q_data_i.cmd == ectp_pkg::CMD_FIRST || q_data_i.cmd == ectp_pkg::CMD_EDGE) begin
              wait_q <= 1'b0;
            end
            if (q_data_i.cmd == ectp_pkg::CMD_EDGE) begin
              quo_q   <= {q_data_i.interval, {Frac{1'b0}}};
              state_q <= S_DIV;
            end else if (q_data_i.cmd == ectp_pkg::CMD_LOW) begin
              quo_q   <= {{Frac{1'b0}}, q_data_i.interval};
              state_q <= S_DIV;
            end else begin
              state_q <= S_OUT;
            end
          end
        end
        S_DIV: begin
          rem_q <= ge ? 32'(r_sh - {1'b0, dsr}) : r_sh[31:0];
          quo_q <= {quo_q[DvdW-2:0], ge};
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CntW'(DvdW - 1)) begin
            state_q <= S_POST;
          end
        end
        S_POST: begin
          cnt_q <= '0;
          pb_q  <= '0;
          if (cmd_q == ectp_pkg::CMD_EDGE) begin
            tp_q    <= tp_sat;
            state_q <= (tp_sat == '0) ? S_OUT : S_DBL;
          end else if (elapsed > DvdW'(twice)) begin
            ext_q   <= 1'b0;
            wait_q  <= 1'b0;
            prog_q  <= '0;
            state_q <= S_OUT;
          end else if (elapsed > DvdW'(period_q) && ext_q) begin
            pr_q    <= 34'(elapsed);
            state_q <= S_PROG;
          end else begin
            state_q <= S_OUT;
          end
        end
        S_DBL: begin
          if (tp_q < cfg_i.min_period) begin
            tp_q <= tp_q[31] ? '1 : {tp_q[30:0], 1'b0};
          end else begin
            state_q <= S_UPD;
          end
        end
        S_UPD: begin
          if (diff != '0) begin
            resync_q <= (period_q == '0) || (diff100 > 39'(period_q));
            period_q <= (period_q == '0) ? tp_q : blend[34:3];
            recalc_q <= 1'b1;
          end
          ext_q   <= 1'b1;
          state_q <= S_OUT;
        end
        S_PROG: begin
          pb_q  <= {pb_q[7:0], pbit};
          pr_q  <= (pr_q - (pbit ? 34'(twice) : 34'd0)) << 1;
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CntW'(8)) begin
            state_q <= S_PFIN;
          end
        end
        S_PFIN: begin
          wait_q  <= 1'b1;
          prog_q  <= pb_q[8] ? 8'hFF : pb_q[7:0];
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid_q || pop) begin
            out_q.smoothed_period <= period_q;
            out_q.external_active <= ext_q;
            out_q.waiting_flag    <= wait_q;
            out_q.wait_progress   <= prog_q;
            out_q.resync_pulse    <= resync_q;
            out_q.recalc_pulse    <= recalc_q;
            out_valid_q           <= 1'b1;
            state_q               <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_dbl_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DBL |-> tp_q != '0) else $error("doubling a zero period");

  a_resync_recalc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.resync_pulse |-> out_q.recalc_pulse)
    else $error("resync without recalc");

  a_prog_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_PROG |-> (pr_q >> 1) <= 34'(twice))
    else $error("progress remainder out of range");

endmodule

FILE: design/ext_clock_period_tracker_core.sv
`timescale 1ns / 1ps
// Follows an external clock (jack, or bus line when allowed) and keeps a smoothed
// Q16.16 period in ticks, with timeout, waiting and progress status. Each word
// pushed gives one result word. An accepted word is registered into a 4-word
// queue. From its head a held or first-edge sample goes straight to the output
// state; an edge or low sample runs a 48-bit bit-serial divider, then, if nonzero,
// doubling up to the minimum period (edge) or, when overdue, 9 progress-division
// steps and a closing state (low). A result left unpopped holds the arithmetic
// while the queue keeps taking words until it is full.
module ext_clock_period_tracker_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  ectp_pkg::in_word_t  in_word_i,
  output logic                empty,
  input  logic                pop,
  output ectp_pkg::out_word_t out_word_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [1:0]          cfg_index_i,
  input  logic [31:0]         cfg_data_i
);

  ectp_pkg::cfg_t cfg_q;
  ectp_pkg::cmd_t cmd_w, cmd_r;
  logic           cmd_wr, q_rd, q_full, q_empty;

  assign cfg_ready_o = 1'b1;
  assign full        = q_full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.allow_bus       <= 1'b0;
      cfg_q.cycles_per_tick <= 32'd27000;
      cfg_q.min_period      <= 32'd65536;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        ectp_pkg::REG_ALLOW_BUS: cfg_q.allow_bus       <= cfg_data_i[0];
        ectp_pkg::REG_CYCLES:    cfg_q.cycles_per_tick <= cfg_data_i;
        ectp_pkg::REG_MIN:       cfg_q.min_period      <= cfg_data_i;
        default:                 cfg_q                 <= cfg_q;
      endcase
    end
  end

  ectp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .in_word_i   (in_word_i),
    .cfg_i       (cfg_q),
    .q_full_i    (q_full),
    .cmd_valid_o (cmd_wr),
    .cmd_o       (cmd_w)
  );

  ectp_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (cmd_wr),
    .wdata_i (cmd_w),
    .rd_i    (q_rd),
    .rdata_o (cmd_r),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  ectp_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .q_empty_i  (q_empty),
    .q_data_i   (cmd_r),
    .q_rd_o     (q_rd),
    .pop        (pop),
    .empty      (empty),
    .out_word_o (out_word_o)
  );

endmodule

FILE: tb/sv/ext_clock_period_tracker_core_test.sv
`timescale 1ns / 1ps
module ext_clock_period_tracker_core_test;

  logic                clk_i;
  logic                rst_ni;
  logic                push;
  logic                full;
  ectp_pkg::in_word_t  in_word_i;
  logic                empty;
  logic                pop;
  ectp_pkg::out_word_t out_word_o;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [1:0]          cfg_index_i;
  logic [31:0]         cfg_data_i;

  ext_clock_period_tracker_core DUT (.*);

  // tracker shadow state
  logic        m_allow;
  logic [31:0] m_cpt;
  logic [31:0] m_min;
  logic [31:0] m_last_edge;
  logic        m_seen;
  logic        m_high;
  logic [31:0] m_period;
  logic        m_ext;
  logic        m_wait;
  logic [7:0]  m_prog;

  ectp_pkg::out_word_t pending_words[$];
  int                  errors;
  int                  send_idle;
  int                  recv_stall;

  typedef struct packed {
    logic                typed;
    ectp_pkg::in_word_t  w;
    ectp_pkg::out_word_t res;
  } row_t;

  function automatic ectp_pkg::out_word_t track_sample(ectp_pkg::in_word_t w);
    logic [31:0]         ivl;
    logic                lvl;
    logic [63:0]         dv;
    logic [63:0]         tp;
    logic [63:0]         diff;
    logic [63:0]         elapsed;
    logic [63:0]         twice;
    logic [63:0]         p;
    ectp_pkg::out_word_t r;
    ivl = w.timestamp - m_last_edge;
    dv = (m_cpt == 0) ? 64'd1 : {32'd0, m_cpt};
    r = '0;
    if (w.jack_present) lvl = w.jack_level;
    else if (m_allow) lvl = w.bus_level;
    else lvl = 1'b0;
    if (lvl && !m_high) begin
      m_high = 1'b1;
      m_wait = 1'b0;
      if (m_seen) begin
        tp = ({32'd0, ivl} << ectp_pkg::FracBits) / dv;
        if (tp > 64'hFFFF_FFFF) tp = 64'hFFFF_FFFF;
        if (tp != 0) begin
          while (tp < {32'd0, m_min}) begin
            tp = tp << 1;
            if (tp > 64'hFFFF_FFFF) tp = 64'hFFFF_FFFF;
          end
          diff = (tp > m_period) ? tp - m_period : {32'd0, m_period} - tp;
          if (diff != 0) begin
            if (m_period == 0 || diff * 100 > {32'd0, m_period}) r.resync_pulse = 1'b1;
            if (m_period == 0) m_period = tp[31:0];
            else m_period = 32'(({32'd0, m_period} * 7 + tp) >> 3);
            r.recalc_pulse = 1'b1;
          end
          m_ext = 1'b1;
        end
      end
      m_seen = 1'b1;
      m_last_edge = w.timestamp;
    end
    if (!lvl) begin
      elapsed = ({32'd0, ivl} / dv) << ectp_pkg::FracBits;
      twice = {32'd0, m_period} * 2;
      m_high = 1'b0;
      if (elapsed > twice) begin
        m_wait = 1'b0;
        m_ext = 1'b0;
        m_prog = '0;
      end else if (elapsed > {32'd0, m_period} && m_ext) begin
        p = (elapsed * 256) / twice;
        m_wait = 1'b1;
        m_prog = (p > 255) ? 8'd255 : p[7:0];
      end
    end
    r.smoothed_period = m_period;
    r.external_active = m_ext;
    r.waiting_flag = m_wait;
    r.wait_progress = m_prog;
    return r;
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #20ms;
    $display("** ext_clock_period_tracker_core: FAILED **");
    $finish;
  end

  always @(posedge clk_i) begin
    ectp_pkg::out_word_t e;
    if (rst_ni && pop && !empty) begin
      if (pending_words.size() == 0) begin
        $display("%t unexpected word %h", $time, out_word_o);
        errors++;
      end else begin
        e = pending_words.pop_front();
        if (e.smoothed_period !== out_word_o.smoothed_period)
          $display("%t period exp %h got %h", $time, e.smoothed_period,
                   out_word_o.smoothed_period);
        if (e.external_active !== out_word_o.external_active)
          $display("%t active exp %b got %b", $time, e.external_active,
                   out_word_o.external_active);
        if (e.waiting_flag !== out_word_o.waiting_flag)
          $display("%t waiting exp %b got %b", $time, e.waiting_flag,
                   out_word_o.waiting_flag);
        if (e.wait_progress !== out_word_o.wait_progress)
          $display("%t progress exp %h got %h", $time, e.wait_progress,
                   out_word_o.wait_progress);
        if (e.resync_pulse !== out_word_o.resync_pulse)
          $display("%t resync exp %b got %b", $time, e.resync_pulse,
                   out_word_o.resync_pulse);
        if (e.recalc_pulse !== out_word_o.recalc_pulse)
          $display("%t recalc exp %b got %b", $time, e.recalc_pulse,
                   out_word_o.recalc_pulse);
        if (e !== out_word_o) errors++;
      end
    end
    pop <= ($urandom_range(0, 99) >= recv_stall);
  end

  task automatic send_word(ectp_pkg::in_word_t w, logic typed, ectp_pkg::out_word_t res);
    ectp_pkg::out_word_t pr;
    push <= 1'b1;
    in_word_i <= w;
    do @(posedge clk_i); while (full);
    pr = track_sample(w);
    pending_words.push_back(typed ? res : pr);
    if ($urandom_range(0, 99) < send_idle) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  task automatic write_reg(ectp_pkg::reg_e idx, logic [31:0] d);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= d;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      ectp_pkg::REG_ALLOW_BUS: m_allow = d[0];
      ectp_pkg::REG_CYCLES:    m_cpt = d;
      default:                 m_min = d;
    endcase
    @(posedge clk_i);
  endtask

  task automatic drain();
    push <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  initial begin
    row_t               rows[$];
    logic [31:0]        set_allow[6] = '{1, 1, 0, 1, 1, 0};
    logic [31:0]        set_cpt[6]   = '{27000, 1, 50, 32'hFFFF_FFFF, 7, 13};
    logic [31:0]        set_min[6]   = '{65536, 1, 32'hFFFF_FFFF, 65536, 300000, 1};
    logic [63:0]        half;
    logic [63:0]        pos;
    logic [31:0]        ts;
    logic               lvl;
    logic [31:0]        step;
    ectp_pkg::in_word_t w;

    errors = 0;
    send_idle = 31;
    recv_stall = 52;
    push = 1'b0;
    pop = 1'b0;
    in_word_i = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = ectp_pkg::REG_ALLOW_BUS;
    cfg_data_i = '0;
    m_allow = 1'b0; m_cpt = 27000; m_min = 65536;
    m_last_edge = '0; m_seen = 0; m_high = 0; m_period = '0;
    m_ext = 0; m_wait = 0; m_prog = '0;
    rst_ni = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    rows = '{
      '{1, '{1, 0, 0, 32'd0},     '{32'd0, 0, 0, 8'd0, 0, 0}},
      '{1, '{1, 1, 0, 32'd100},   '{32'd0, 0, 0, 8'd0, 0, 0}},
      '{1, '{1, 0, 0, 32'd200},   '{32'd0, 0, 0, 8'd0, 0, 0}},
      '{1, '{1, 1, 0, 32'd27100}, '{32'd65536, 1, 0, 8'd0, 1, 1}},
      '{1, '{1, 0, 0, 32'd81100}, '{32'd65536, 1, 1, 8'd255, 0, 0}},
      '{1, '{1, 0, 1, 32'd108100}, '{32'd65536, 0, 0, 8'd0, 0, 0}},
      '{1, '{1, 1, 1, 32'd54100}, '{32'd65536, 1, 0, 8'd0, 0, 0}},
      '{1, '{1, 1, 0, 32'd54100}, '{32'd65536, 1, 0, 8'd0, 0, 0}},
      '{0, '{1, 0, 0, 32'd54200}, '0},
      '{0, '{1, 1, 0, 32'd54100}, '0},
      '{0, '{1, 0, 0, 32'd60000}, '0},
      '{0, '{1, 1, 0, 32'd64000}, '0},
      '{0, '{0, 1, 1, 32'd70000}, '0},
      '{0, '{0, 0, 1, 32'd90000}, '0},
      '{0, '{1, 1, 1, 32'd93000}, '0},
      '{0, '{1, 0, 1, 32'hFFFF_FFFF}, '0},
      '{0, '{1, 1, 0, 32'hFFFF_FFFF}, '0},
      '{0, '{1, 0, 0, 32'd10}, '0},
      '{0, '{1, 1, 1, 32'd27000}, '0},
      '{0, '{1, 0, 1, 32'd30000}, '0},
      '{0, '{1, 1, 1, 32'd57000}, '0}
    };
    foreach (rows[i]) send_word(rows[i].w, rows[i].typed, rows[i].res);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      send_idle = (ph < 2) ? 31 : (ph < 4) ? 52 : 0;
      recv_stall = (ph < 2) ? 52 : (ph < 4) ? 31 : 0;
      write_reg(ectp_pkg::REG_ALLOW_BUS, set_allow[ph]);
      write_reg(ectp_pkg::REG_CYCLES, set_cpt[ph]);
      write_reg(ectp_pkg::REG_MIN, set_min[ph]);
      half = {32'd0, m_cpt} * $urandom_range(1, 8);
      if (half > 64'h7FFF_FFFF) half = 64'h7FFF_FFFF;
      ts = $urandom;
      pos = 0;
      lvl = 0;
      for (int n = 0; n < 270; n++) begin
        if ($urandom_range(0, 99) < 10) begin
          w = {1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
               1'($urandom_range(0, 1)), 32'($urandom)};
        end else begin
          if ($urandom_range(0, 99) < 3) step = 32'(half * 6);
          else step = $urandom_range(1, 32'(half / 3) + 1);
          if ($urandom_range(0, 99) < 5) half = half + (half >> 4) + 1;
          if (half > 64'h7FFF_FFFF) half = 64'h7FFF_FFFF;
          ts += step;
          pos += step;
          while (pos >= half) begin
            pos -= half;
            lvl = ~lvl;
          end
          w.timestamp = ts;
          w.jack_present = (m_allow) ? ($urandom_range(0, 99) < 50) : 1'b1;
          if ($urandom_range(0, 99) < 5) w.jack_present = ~w.jack_present;
          w.jack_level = w.jack_present ? lvl : 1'($urandom_range(0, 1));
          w.bus_level = w.jack_present ? 1'($urandom_range(0, 1)) : lvl;
        end
        send_word(w, 1'b0, '0);
      end
      drain();
    end

    if (errors == 0) $display("** ext_clock_period_tracker_core: PASSED **");
    else $display("** ext_clock_period_tracker_core: FAILED **");
    $finish;
  end

endmodule
